FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CNV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CNV_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define CNV_ASSERT(lbl, prop, msg)
`define CNV_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: hw/rtl/cnv_pkg.sv
// ----------------------------------------------------------------------------
// cnv_pkg
// Shared constants and types of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package cnv_pkg;

  localparam int MaxWidthDef      = 256;
  localparam int CoeffWidthDef    = 16;
  localparam int CoeffFracBitsDef = 4;

  localparam int PixW      = 8;
  localparam int RowW      = 12;
  localparam int ColOutW   = 8;
  localparam int CfgW      = 48;
  localparam int WidthRegW = 9;
  localparam int HeightRegW = 13;
  localparam int CfgIdxW   = 3;

  localparam logic [HeightRegW-1:0] HeightLimit = 13'd4096;
  localparam logic [PixW-1:0]       PixMax      = 8'd255;
  localparam logic [PixW-1:0]       PixMin      = 8'd0;

  localparam logic [WidthRegW-1:0]  WidthRst    = 9'd256;
  localparam logic [HeightRegW-1:0] HeightRst   = 13'd256;
  localparam logic [CfgW-1:0]       CoeffTopRst = 48'hFFEC0000FFEC;
  localparam logic [CfgW-1:0]       CoeffMidRst = 48'h0000_00A00000;
  localparam logic [CfgW-1:0]       CoeffBotRst = 48'hFFEC0000FFEC;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_COEFF_TOP = 3'd2,
    REG_COEFF_MID = 3'd3,
    REG_COEFF_BOT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic            done;
    logic [PixW-1:0] value;
  } filt_res_t;

endpackage

FILE: hw/rtl/image_3x3_convolution_filter.sv
// ----------------------------------------------------------------------------
// image_3x3_convolution_filter
// 3x3 normalized convolution over a raster-order 8-bit pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on pixel_in_i with valid/ready; results leave on the out_*
// channel with valid/ready, each carrying row, column, value, last_of_run and
// frame_end. Geometry and coefficients are written over cfg_we_i/cfg_index_i/
// cfg_data_i only while the block is idle, a rule for the user that the block
// does not enforce; a geometry write restarts at (0,0). One pixel is processed
// at a time. The row buffers are read at acceptance and their data is used in
// the following cycle (S_READ), where a border-only pixel registers its result.
// An interior result passes through the multiply-accumulate over the nine taps,
// one setup step and the bit-serial divider, which a negative result skips as
// it is clamped to zero; the divider takes the longest of these steps.
// A pixel that completes an interior and a border result delivers two
// transactions, interior first. The next pixel is taken once all results of
// the current one are delivered; a stalled receiver holds the block.
// Reset clears counters and loads the default geometry and coefficients; the
// row buffers need no clearing since every entry is written before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module image_3x3_convolution_filter #(
  parameter int MAX_WIDTH       = cnv_pkg::MaxWidthDef,
  parameter int COEFF_WIDTH     = cnv_pkg::CoeffWidthDef,
  parameter int COEFF_FRAC_BITS = cnv_pkg::CoeffFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cnv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cnv_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [cnv_pkg::PixW-1:0]      pixel_in_i,
  input  logic                          pixel_in_valid_i,
  output logic                          pixel_in_ready_o,
  output logic [cnv_pkg::RowW-1:0]      out_row_o,
  output logic [cnv_pkg::ColOutW-1:0]   out_column_o,
  output logic [cnv_pkg::PixW-1:0]      pixel_value_o,
  output logic                          last_of_run_o,
  output logic                          frame_end_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > cnv_pkg::WidthRegW) ? WW : cnv_pkg::WidthRegW;
  localparam int HW = cnv_pkg::HeightRegW;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_FILT, S_OUT} state_e;

  state_e                              state_q;
  logic [cnv_pkg::WidthRegW-1:0]       width_q;
  logic [HW-1:0]                       height_q;
  logic [2:0][cnv_pkg::CfgW-1:0]       coeff_q;
  logic [AW-1:0]                       col_q, c_q;
  logic [cnv_pkg::RowW-1:0]            row_q, r_q;
  logic [cnv_pkg::PixW-1:0]            pix_q;
  logic [5:0][cnv_pkg::PixW-1:0]       win_q;
  logic                                int_q, bdr_q, fend_q, pend_q;

  logic [EW-1:0]                       w_eff, col_p1, c_ext;
  logic [HW-1:0]                       h_eff, row_p1, r_ext;
  logic                                in_acc, out_acc, has_int, has_bdr, is_fend;
  logic [cnv_pkg::PixW-1:0]            top_rd, mid_rd;
  logic [8:0][cnv_pkg::PixW-1:0]       px;
  cnv_pkg::filt_res_t                  filt;

  always_comb begin
    if (width_q < cnv_pkg::WidthRegW'(3)) begin
      w_eff = EW'(3);
    end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_q);
    end
    if (height_q < HW'(3)) begin
      h_eff = HW'(3);
    end else if (height_q > cnv_pkg::HeightLimit) begin
      h_eff = cnv_pkg::HeightLimit;
    end else begin
      h_eff = height_q;
    end
    col_p1  = EW'(col_q) + EW'(1);
    row_p1  = HW'(row_q) + HW'(1);
    c_ext   = EW'(c_q);
    r_ext   = HW'(r_q);
    has_int = (r_q >= cnv_pkg::RowW'(2)) && (c_ext >= EW'(2));
    has_bdr = (r_q == '0) || (r_ext == h_eff - HW'(1)) ||
              (c_q == '0) || (c_ext == w_eff - EW'(1));
    is_fend = (r_ext == h_eff - HW'(1)) && (c_ext == w_eff - EW'(1));
    px[0] = win_q[0];
    px[1] = win_q[3];
    px[2] = top_rd;
    px[3] = win_q[1];
    px[4] = win_q[4];
    px[5] = mid_rd;
    px[6] = win_q[2];
    px[7] = win_q[5];
    px[8] = pix_q;
  end

  assign pixel_in_ready_o = (state_q == S_IDLE);
  assign in_acc           = pixel_in_valid_i && pixel_in_ready_o;
  assign out_acc          = out_valid_o && out_ready_i;

  cnv_line_store #(
    .Depth (MAX_WIDTH),
    .AddrW (AW)
  ) u_line_store (
    .clk_i         (clk_i),
    .re_i          (in_acc),
    .we_i          (state_q == S_READ),
    .addr_i        ((state_q == S_READ) ? c_q : col_q),
    .older_wdata_i (mid_rd),
    .newer_wdata_i (pix_q),
    .older_rdata_o (top_rd),
    .newer_rdata_o (mid_rd)
  );

  cnv_filter #(
    .CoeffWidth    (COEFF_WIDTH),
    .CoeffFracBits (COEFF_FRAC_BITS)
  ) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == S_READ) && has_int),
    .px_i    (px),
    .coeff_i (coeff_q),
    .res_o   (filt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= cnv_pkg::WidthRst;
      height_q    <= cnv_pkg::HeightRst;
      coeff_q[0]  <= cnv_pkg::CoeffTopRst;
      coeff_q[1]  <= cnv_pkg::CoeffMidRst;
      coeff_q[2]  <= cnv_pkg::CoeffBotRst;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_o <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cnv_pkg::REG_WIDTH: begin
            width_q <= cfg_data_i[cnv_pkg::WidthRegW-1:0];
            col_q   <= '0;
            row_q   <= '0;
          end
          cnv_pkg::REG_HEIGHT: begin
            height_q <= cfg_data_i[HW-1:0];
            col_q    <= '0;
            row_q    <= '0;
          end
          cnv_pkg::REG_COEFF_TOP: coeff_q[0] <= cfg_data_i;
          cnv_pkg::REG_COEFF_MID: coeff_q[1] <= cfg_data_i;
          cnv_pkg::REG_COEFF_BOT: coeff_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pix_q <= pixel_in_i;
            r_q   <= row_q;
            c_q   <= col_q;
            if (col_p1 >= w_eff) begin
              col_q <= '0;
              row_q <= (row_p1 >= h_eff) ? '0 : row_p1[cnv_pkg::RowW-1:0];
            end else begin
              col_q <= col_p1[AW-1:0];
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          win_q[0] <= win_q[3];
          win_q[1] <= win_q[4];
          win_q[2] <= win_q[5];
          win_q[3] <= top_rd;
          win_q[4] <= mid_rd;
          win_q[5] <= pix_q;
          int_q    <= has_int;
          bdr_q    <= has_bdr;
          fend_q   <= is_fend;
          if (has_int) begin
            state_q <= S_FILT;
          end else if (has_bdr) begin
            out_row_o     <= r_q;
            out_column_o  <= cnv_pkg::ColOutW'(c_q);
            pixel_value_o <= pix_q;
            last_of_run_o <= 1'b1;
            frame_end_o   <= is_fend;
            out_valid_o   <= 1'b1;
            pend_q        <= 1'b0;
            state_q       <= S_OUT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FILT: begin
          if (filt.done) begin
            out_row_o     <= r_q - cnv_pkg::RowW'(1);
            out_column_o  <= cnv_pkg::ColOutW'(c_q - AW'(1));
            pixel_value_o <= filt.value;
            last_of_run_o <= !bdr_q;
            frame_end_o   <= 1'b0;
            out_valid_o   <= 1'b1;
            pend_q        <= bdr_q;
            state_q       <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (pend_q) begin
              out_row_o     <= r_q;
              out_column_o  <= cnv_pkg::ColOutW'(c_q);
              pixel_value_o <= pix_q;
              last_of_run_o <= 1'b1;
              frame_end_o   <= fend_q;
              pend_q        <= 1'b0;
            end else begin
              out_valid_o <= 1'b0;
              state_q     <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CNV_ASSERT_NEVER(a_in_out_excl, pixel_in_ready_o && out_valid_o, "input taken while output pending")
  `CNV_ASSERT(a_fend_last, out_valid_o && frame_end_o |-> last_of_run_o, "frame_end without last_of_run")
  `CNV_ASSERT(a_done_in_filt, filt.done |-> state_q == S_FILT, "filter done outside filter wait")
  `CNV_ASSERT(a_col_range, EW'(col_q) < w_eff || $past(cfg_we_i), "column counter beyond width")
  `CNV_ASSERT(a_pend_int, pend_q |-> int_q && bdr_q, "second result pending without two results")

endmodule

FILE: hw/rtl/cnv_line_store.sv
// ----------------------------------------------------------------------------
// cnv_line_store
// Two row buffers sharing one address, with a registered synchronous read.
// ----------------------------------------------------------------------------
module cnv_line_store #(
  parameter int Depth = cnv_pkg::MaxWidthDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         addr_i,
  input  logic [cnv_pkg::PixW-1:0] older_wdata_i,
  input  logic [cnv_pkg::PixW-1:0] newer_wdata_i,
  output logic [cnv_pkg::PixW-1:0] older_rdata_o,
  output logic [cnv_pkg::PixW-1:0] newer_rdata_o
);

  logic [cnv_pkg::PixW-1:0] older_mem [Depth];
  logic [cnv_pkg::PixW-1:0] newer_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      older_mem[addr_i] <= older_wdata_i;
      newer_mem[addr_i] <= newer_wdata_i;
    end
    if (re_i) begin
      older_rdata_o <= older_mem[addr_i];
      newer_rdata_o <= newer_mem[addr_i];
    end
  end

endmodule

FILE: hw/rtl/cnv_filter.sv
// ----------------------------------------------------------------------------
// cnv_filter
// Sequential 3x3 multiply-accumulate followed by a restoring divider.
// ----------------------------------------------------------------------------
module cnv_filter #(
  parameter int CoeffWidth    = cnv_pkg::CoeffWidthDef,
  parameter int CoeffFracBits = cnv_pkg::CoeffFracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [8:0][cnv_pkg::PixW-1:0]   px_i,
  input  logic [2:0][cnv_pkg::CfgW-1:0]   coeff_i,
  output cnv_pkg::filt_res_t              res_o
);

  localparam int SW  = CoeffWidth + 13;
  localparam int KW  = CoeffWidth + 4;
  localparam int DCW = $clog2(SW);
  localparam int ExtW = 3 * CoeffWidth + cnv_pkg::CfgW;
  localparam logic [SW-1:0] FracMask = ~((SW'(1) << CoeffFracBits) - SW'(1));
  localparam logic [DCW-1:0] DivLast = DCW'(SW - 1);

  typedef enum logic [2:0] {F_IDLE, F_MAC, F_SETUP, F_DIV, F_DONE} fstate_e;

  fstate_e                        state_q;
  logic [3:0]                     cnt_q;
  logic [DCW-1:0]                 dcnt_q;
  logic [8:0][cnv_pkg::PixW-1:0]  px_q;
  logic signed [SW-1:0]           acc_q;
  logic signed [KW-1:0]           k_q;
  logic [SW-1:0]                  num_q;
  logic [KW-1:0]                  den_q;
  logic [KW-1:0]                  rem_q;
  logic [cnv_pkg::PixW-1:0]       val_q;

  logic signed [CoeffWidth-1:0]   coef [9];
  logic signed [CoeffWidth-1:0]   c_sel;
  logic signed [CoeffWidth+8:0]   prod;
  logic                           acc_neg, k_neg, k_zero, res_neg;
  logic [SW-1:0]                  mag;
  logic [KW-1:0]                  kmag;
  logic [KW:0]                    rem_sh;
  logic                           qbit;

  for (genvar i = 0; i < 9; i++) begin : g_coef
    logic [ExtW-1:0] ext;
    assign ext     = ExtW'(coeff_i[i / 3]);
    assign coef[i] = ext[(i % 3) * CoeffWidth +: CoeffWidth];
  end

  always_comb begin
    c_sel   = coef[cnt_q];
    prod    = $signed({1'b0, px_q[cnt_q]}) * c_sel;
    acc_neg = acc_q[SW-1];
    k_neg   = k_q[KW-1];
    k_zero  = (k_q == '0);
    res_neg = acc_neg ^ (k_neg && !k_zero);
    mag     = acc_neg ? SW'(-acc_q) : SW'(acc_q);
    kmag    = k_neg ? KW'(-k_q) : KW'(k_q);
    rem_sh  = {rem_q, num_q[SW-1]};
    qbit    = (rem_sh >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (start_i) begin
            px_q    <= px_i;
            acc_q   <= '0;
            k_q     <= '0;
            cnt_q   <= '0;
            state_q <= F_MAC;
          end
        end
        F_MAC: begin
          acc_q <= acc_q + SW'(prod);
          k_q   <= k_q + KW'(c_sel);
          if (cnt_q == 4'd8) begin
            cnt_q   <= '0;
            state_q <= F_SETUP;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        F_SETUP: begin
          if (res_neg) begin
            val_q   <= cnv_pkg::PixMin;
            num_q   <= '0;
            state_q <= F_DONE;
          end else begin
            num_q   <= mag & FracMask;
            den_q   <= k_zero ? (KW'(1) << CoeffFracBits) : kmag;
            rem_q   <= '0;
            dcnt_q  <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          rem_q  <= qbit ? KW'(rem_sh - {1'b0, den_q}) : KW'(rem_sh);
          num_q  <= {num_q[SW-2:0], qbit};
          dcnt_q <= dcnt_q + DCW'(1);
          if (dcnt_q == DivLast) begin
            state_q <= F_DONE;
          end
        end
        F_DONE: begin
          if (num_q[SW-1:cnv_pkg::PixW] != '0) begin
            val_q <= cnv_pkg::PixMax;
          end else begin
            val_q <= num_q[cnv_pkg::PixW-1:0];
          end
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  // value settles the cycle after F_DONE, so flag done from a delayed strobe
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == F_DONE);
    end
  end

  assign res_o.done  = done_q;
  assign res_o.value = val_q;

endmodule
